// ===== src/itf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package itf_pkg;
    localparam int MAX_CHARS = 64;
    localparam int CW = $clog2(MAX_CHARS + 1);

    typedef struct packed {
        logic [63:0] value;
        logic [5:0]  radix;
        logic [6:0]  pad_width;
        logic [6:0]  min_digits;
        logic        left_align;
        logic        show_plus;
        logic        show_space;
        logic        alt_prefix;
        logic        zero_fill;
        logic        lower_case;
        logic        is_signed;
    } in_item_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad_radix;
        logic       truncated;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic [63:0] mag;
        logic [5:0]  radix;
        logic        bad;
        logic [7:0]  sign_ch;   // 0 = none
        logic [1:0]  pfx_len;
        logic [7:0]  x_ch;
        logic [7:0]  lead_sp;
        logic [7:0]  pad_zero;
        logic [7:0]  trail_sp;
        logic [7:0]  prec;
        logic        lower;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_LEAD, B_SIGN, B_PFX, B_ZERO, B_DIG, B_TRAIL
    } bstate_t;

    function automatic logic [7:0] digit_ch(input logic [5:0] d, input logic lower);
        logic [7:0] c;
        begin
            if (d < 6'd10) c = 8'h30 + {2'b00, d};
            else c = (lower ? 8'h61 : 8'h41) + {2'b00, d} - 8'd10;
            return c;
        end
    endfunction
endpackage
`default_nettype wire

// ===== src/itf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module itf_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire itf_pkg::in_item_t item,
    input  wire logic             take,
    output itf_pkg::job_t         job_reg
);
    import itf_pkg::*;
    logic        neg;
    logic [63:0] mag;
    logic [7:0]  sgn;
    logic [1:0]  pl;
    logic        zf;
    job_t        job_next;

    // classify sign, prefix and static padding inputs
    always_comb
    begin
        neg = item.is_signed & item.value[63];
        mag = neg ? (64'd0 - item.value) : item.value;
        sgn = neg ? 8'h2D : item.show_plus ? 8'h2B : item.show_space ? 8'h20 : 8'h00;
        pl  = !item.alt_prefix ? 2'd0 : (item.radix == 6'd16) ? 2'd2 :
              (item.radix == 6'd8) ? 2'd1 : 2'd0;
        zf  = item.zero_fill & ~item.left_align;
        job_next          = '0;
        job_next.mag      = mag;
        job_next.radix    = item.radix;
        job_next.bad      = (item.radix < 6'd2) || (item.radix > 6'd36);
        job_next.sign_ch  = sgn;
        job_next.pfx_len  = pl;
        job_next.x_ch     = item.lower_case ? 8'h78 : 8'h58;
        // lead_sp = width - sign - prefix; zero/trail pads are flags; back resolves digits
        job_next.lead_sp  = {1'b0, item.pad_width} - {7'd0, sgn != 8'h00} - {6'd0, pl};
        job_next.pad_zero = {7'd0, zf};
        job_next.trail_sp = {7'd0, item.left_align};
        job_next.prec     = {1'b0, item.min_digits};
        job_next.lower    = item.lower_case;
    end

    // hold the classified job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) job_reg <= '0;
        else if (take) job_reg <= job_next;
    end
endmodule
`default_nettype wire

// ===== src/itf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module itf_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire itf_pkg::job_t  job,
    input  wire logic           job_valid,
    output logic                job_take,
    output itf_pkg::out_item_t  result,
    output logic                result_valid,
    input  wire logic           result_take
);
    import itf_pkg::*;
    bstate_t     state_reg, state_next;
    job_t        j_reg;
    logic [63:0] q_reg, q_next;
    logic [63:0] rem_reg, rem_next;
    logic [6:0]  bit_reg, bit_next;
    logic [5:0]  dig_reg [64];
    logic [5:0]  dig_rd_reg;
    logic [5:0]  rd_addr;
    logic [6:0]  nd_reg, nd_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic        rem_up;
    logic [64:0] trial;
    logic [8:0]  size;
    logic [7:0]  prec_eff, lead, zer, trail;
    logic        emit_now;
    logic [7:0]  ch;
    logic        done_item, stop;
    logic [8:0]  total;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial = {rem_reg, q_reg[63]} - {59'd0, j_reg.radix};
        rem_up = ~trial[64];
    end

    // derive padding from digit count
    always_comb
    begin
        prec_eff = ({1'b0, nd_reg} > j_reg.prec) ? {1'b0, nd_reg} : j_reg.prec;
        size = {j_reg.lead_sp[7], j_reg.lead_sp} - {1'b0, prec_eff};
        lead  = (!size[8] && !j_reg.pad_zero[0] && !j_reg.trail_sp[0]) ? size[7:0] : 8'd0;
        zer   = (!size[8] && j_reg.pad_zero[0]) ? size[7:0] : 8'd0;
        trail = (!size[8] && j_reg.trail_sp[0]) ? size[7:0] : 8'd0;
        total = {1'b0, lead} + {8'd0, j_reg.sign_ch != 8'h00} + {7'd0, j_reg.pfx_len}
              + {1'b0, zer} + {1'b0, prec_eff} + {1'b0, trail};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        q_next = q_reg; rem_next = rem_reg; bit_next = bit_reg; nd_next = nd_reg;
        cnt_next = cnt_reg; emit_next = emit_reg;
        stop = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = job.bad ? B_TRAIL : B_DIV;
                    q_next = job.mag; rem_next = '0; bit_next = '0; nd_next = '0;
                    emit_next = '0;
                end
            end
            B_DIV:
            begin
                q_next = {q_reg[62:0], rem_up};
                rem_next = rem_up ? trial[63:0] : {rem_reg[62:0], q_reg[63]};
                bit_next = bit_reg + 7'd1;
                if (bit_reg == 7'd63)
                begin
                    nd_next = nd_reg + 7'd1;
                    bit_next = '0;
                    rem_next = '0;
                    if ({q_reg[62:0], rem_up} == 64'd0 || nd_reg == 7'd63)
                    begin
                        state_next = B_LEAD;
                        cnt_next = '0;
                    end
                end
            end
            default: ;
        endcase
        // emission phases
        if (state_reg != B_IDLE && state_reg != B_DIV && j_reg.bad)
        begin
            if (result_take) state_next = B_IDLE;
        end
        else if (state_reg == B_LEAD || state_reg == B_SIGN || state_reg == B_PFX ||
                 state_reg == B_ZERO || state_reg == B_DIG || state_reg == B_TRAIL)
        begin
            if (!emit_now)
            begin
                cnt_next = '0;
                case (state_reg)
                    B_LEAD:  state_next = B_SIGN;
                    B_SIGN:  state_next = B_PFX;
                    B_PFX:   state_next = B_ZERO;
                    B_ZERO:  state_next = B_DIG;
                    B_DIG:   state_next = B_TRAIL;
                    default: state_next = B_IDLE;
                endcase
            end
            else if (result_take)
            begin
                emit_next = emit_reg + CW'(1);
                cnt_next = cnt_reg + 8'd1;
                if (done_item) stop = 1'b1;
                if (stop) state_next = B_IDLE;
            end
        end
    end

    // point the digit read at the character due next cycle
    always_comb
    begin
        rd_addr = 6'(nd_next - 7'd1 - cnt_next[6:0]);
    end

    // outputs: current character of the active phase
    always_comb
    begin
        emit_now = 1'b0; ch = 8'h00;
        case (state_reg)
            B_LEAD:  begin emit_now = cnt_reg < lead; ch = 8'h20; end
            B_SIGN:  begin emit_now = (j_reg.sign_ch != 8'h00) && cnt_reg == 8'd0;
                         ch = j_reg.sign_ch; end
            B_PFX:   begin emit_now = cnt_reg < {6'd0, j_reg.pfx_len};
                         ch = (cnt_reg == 8'd1) ? j_reg.x_ch : 8'h30; end
            B_ZERO:  begin emit_now = cnt_reg < zer + prec_eff - {1'b0, nd_reg};
                         ch = 8'h30; end
            B_DIG:   begin emit_now = cnt_reg < {1'b0, nd_reg};
                         ch = digit_ch(dig_rd_reg, j_reg.lower); end
            B_TRAIL: begin emit_now = j_reg.bad || cnt_reg < trail; ch = 8'h20; end
            default: ;
        endcase
        if (j_reg.bad) ch = 8'h00;
        done_item = j_reg.bad || (9'(emit_reg) == 9'(MAX_CHARS) - 9'd1)
                 || (9'(emit_reg) == total - 9'd1);
        result_valid = (state_reg != B_IDLE) && (state_reg != B_DIV) && emit_now;
        result.ch = ch;
        result.last = done_item;
        result.bad_radix = j_reg.bad;
        result.truncated = !j_reg.bad && done_item && total > 9'(MAX_CHARS);
        job_take = (state_reg == B_IDLE) && job_valid;
    end

    // advance registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE; emit_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; emit_reg <= emit_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload registers and digit store
    always_ff @(posedge clk)
    begin
        q_reg <= q_next; rem_reg <= rem_next; bit_reg <= bit_next; nd_reg <= nd_next;
        if (job_take) j_reg <= job;
        if (state_reg == B_DIV && bit_reg == 7'd63)
            dig_reg[nd_reg[5:0]] <= rem_up ? trial[5:0] : {rem_reg[4:0], q_reg[63]};
        dig_rd_reg <= dig_reg[rd_addr];
    end
endmodule
`default_nettype wire

// ===== src/integer_to_text_formatter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Handshake        | Payload
// input   | in  | push / full      | request (in_item_t)
// result  | out | pop / empty      | result  (out_item_t)
// The back takes a queued job when idle, then works out each digit on the
// bit-serial divider (one digit for zero, at most 64 digits); a bad radix skips it.
// Emission gives one character per cycle while pop is high, and steps through
// each layout phase that ends before the last character with empty high.
// Reset is asynchronous; the front slot and back sequencer clear to empty.
// The front holds one classified item while the back works, so a stalled
// pop delays the back, and full is high whenever that item is held.
module integer_to_text_formatter_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire itf_pkg::in_item_t  request,
    output logic                    empty,
    input  wire logic               pop,
    output itf_pkg::out_item_t      result
);
    import itf_pkg::*;
    job_t job;
    logic slot_reg, slot_next, take, ov;
    logic in_take;

    assign full = slot_reg;
    assign in_take = push & ~slot_reg;
    // hold one queued job between front and back
    always_comb slot_next = in_take ? 1'b1 : (take ? 1'b0 : slot_reg);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) slot_reg <= 1'b0;
        else slot_reg <= slot_next;
    end

    itf_front u_front (.clk(clk), .rst_n(rst_n), .item(request), .take(in_take),
                       .job_reg(job));
    itf_back u_back (.clk(clk), .rst_n(rst_n), .job(job), .job_valid(slot_reg),
                     .job_take(take), .result(result), .result_valid(ov),
                     .result_take(pop & ov));
    assign empty = ~ov;
endmodule
`default_nettype wire
